// ===== design/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg: shared types, constants and helpers of the smooth damp follower
// Holds the word structs, the sequencer codes and the Q16.16 helpers that
// saturate, take magnitudes and finish fixed-point products.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Wide intermediate values are Q16.16 held within +-(2^47 - 1).
  typedef logic signed [47:0] wide_t;
  localparam wide_t WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [49:0] WSUM_MAX = 50'sh7FFF_FFFF_FFFF;

  localparam logic [30:0] ST_MIN   = 31'd7;
  localparam logic [30:0] ST_RESET = 31'd19661;
  localparam logic [30:0] MS_RESET = 31'h7FFF_FFFF;
  localparam logic [47:0] K048     = 48'd31457;
  localparam logic [47:0] K0235    = 48'd15401;
  localparam logic [23:0] X_CAP    = 24'h80_0000;

  // Register indexes of the configuration port.
  localparam logic CFG_SMOOTH_TIME = 1'b0;
  localparam logic CFG_MAX_SPEED   = 1'b1;

  typedef struct packed {
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic        [16:0] delta_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
  } out_word_t;

  // Request to the divide and square root unit.
  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [5:0] steps;
  } div_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } fsm_e;

  typedef enum logic [4:0] {
    ST_OMEGA,
    ST_X,
    ST_X2,
    ST_X3,
    ST_K1,
    ST_K2,
    ST_DECAY,
    ST_LIM,
    ST_SQ,
    ST_ROOT,
    ST_RATIO,
    ST_SC,
    ST_P1,
    ST_TM,
    ST_P2,
    ST_NV,
    ST_Q,
    ST_DOT
  } step_e;

  // Saturating add of two wide values.
  function automatic wide_t wadd(input logic signed [48:0] a, input logic signed [48:0] b);
    logic signed [49:0] s;
    s = 50'(a) + 50'(b);
    if (s > WSUM_MAX) return WIDE_MAX;
    else if (s < -WSUM_MAX) return -WIDE_MAX;
    else return wide_t'(s[47:0]);
  endfunction

  // Magnitude of a signed value below 2^48.
  function automatic logic [47:0] magw(input logic signed [48:0] v);
    logic signed [48:0] n;
    n = -v;
    return v[48] ? n[47:0] : v[47:0];
  endfunction

  // Finish a Q16.16 product: drop the fraction, saturate, apply the sign.
  function automatic wide_t fmul_res(input logic [95:0] prod, input logic neg);
    logic [47:0] m;
    m = (|prod[95:63]) ? 48'(WIDE_MAX) : {1'b0, prod[62:16]};
    return neg ? -wide_t'(m) : wide_t'(m);
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -49'sh8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ===== design/sdf_mul.sv =====
// ----------------------------------------------------------------------------
// sdf_mul: multi-cycle unsigned multiplier
// Forms a 48 by 48 bit product in three passes of a 48 by 16 bit multiply,
// taking the digits of the second operand from the top down.
// ----------------------------------------------------------------------------
module sdf_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output logic        done_o,
  output logic [95:0] prod_o
);
  import sdf_pkg::*;

  logic        busy_q;
  logic [1:0]  cnt_q;
  logic        done_q;
  logic [47:0] a_q;
  logic [47:0] b_q;
  logic [95:0] acc_q;
  logic [63:0] part;

  // One partial product per cycle.
  assign part = a_q * b_q[47:32];

  // Pass control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd2;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 2'd1;
        if (cnt_q == 2'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift and accumulate.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[79:0], 16'b0} + 96'(part);
      b_q   <= {b_q[31:0], 16'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== design/sdf_div.sv =====
// ----------------------------------------------------------------------------
// sdf_div: iterative divider and square root unit
// Restoring division with one quotient bit per cycle, or restoring square
// root with one result bit per cycle, over a numerator streamed from the top.
// ----------------------------------------------------------------------------
module sdf_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdf_pkg::div_req_t req_i,
  input  logic [39:0]      rem0_i,
  input  logic [77:0]      stream_i,
  input  logic [39:0]      divisor_i,
  output logic             done_o,
  output logic [33:0]      quo_o,
  output logic             exact_o
);
  import sdf_pkg::*;

  logic        busy_q;
  logic        sqrt_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [39:0] rem_q;
  logic [77:0] stream_q;
  logic [39:0] divisor_q;
  logic [33:0] quo_q;
  logic [41:0] trial;
  logic [41:0] cand;
  logic        take;

  // One step: bring down one bit (divide) or two bits (root) and try.
  always_comb begin
    if (sqrt_q) begin
      cand  = {rem_q, stream_q[77:76]};
      trial = 42'({quo_q, 2'b01});
    end else begin
      cand  = {1'b0, rem_q, stream_q[77]};
      trial = 42'(divisor_q);
    end
    take = (cand >= trial);
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps - 6'd1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, quotient and numerator stream.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q    <= req_i.sqrt_mode;
      rem_q     <= rem0_i;
      stream_q  <= stream_i;
      divisor_q <= divisor_i;
      quo_q     <= '0;
    end else if (busy_q) begin
      rem_q    <= take ? 40'(cand - trial) : cand[39:0];
      quo_q    <= {quo_q[32:0], take};
      stream_q <= sqrt_q ? {stream_q[75:0], 2'b0} : {stream_q[76:0], 1'b0};
    end
  end

  assign done_o  = done_q;
  assign quo_o   = quo_q;
  assign exact_o = (rem_q == '0);

endmodule

// ===== design/smooth_damp_follower_2d.sv =====
// ----------------------------------------------------------------------------
// smooth_damp_follower_2d: two-dimensional critically damped follower
// A small sequencer walks one update through a shared multi-cycle multiplier
// and a shared bit-serial divide and square root unit, keeping the velocity.
// ----------------------------------------------------------------------------
//  Channel  Handshake                Word
//  in       in_valid_i/in_ready_o    in_word_i: current, target, delta_time
//  out      out_valid_o/out_ready_i  out_word_o: position, speed
//  cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A word whose offset is clamped takes longer, as it adds the ratio divide
// and the scaling multiplies; the divides and the square root take about
// half the time of a word. No new word is taken until the current one is
// done. Reset clears the velocity and loads the register defaults. A result
// that is not taken holds the sequencer at its last step; the config port is
// always ready.
module smooth_damp_follower_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sdf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdf_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [30:0]        cfg_data_i
);
  import sdf_pkg::*;

  fsm_e  state_q, state_d;
  step_e step_q, step_nx;
  logic  ax_q, ax_nx;

  logic [30:0] smooth_time_q, max_speed_q;
  logic signed [31:0] vel_q [2];
  logic signed [31:0] cur_q [2];
  logic signed [31:0] tgt_q [2];
  logic [16:0] dt_q;
  logic [30:0] st_q;
  logic [30:0] omega_q;
  logic [23:0] x_q;
  logic [30:0] x2_q;
  logic [37:0] x3_q;
  logic [39:0] den_q;
  logic [16:0] decay_q;
  logic [45:0] lim_q;
  logic [65:0] sq_q;
  logic [32:0] root_q;
  logic [31:0] ratio_q;
  logic signed [33:0] chv_q [2];
  wide_t wa_q [2];
  wide_t tm_q [2];
  wide_t nv_q [2];
  wide_t o_q [2];
  logic signed [85:0] dot_q;
  out_word_t out_q;
  logic out_valid_q;

  logic        accept, wb_en, out_free, is_div, unit_done, last;
  logic        mul_start, mul_done;
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_prod;
  div_req_t    div_req;
  logic [39:0] div_rem0, div_divisor;
  logic [77:0] div_stream;
  logic [33:0] div_quo;
  logic        div_exact;
  logic        div_done_w;
  logic [39:0] dec_num;

  logic signed [33:0] chv_c;
  logic signed [31:0] cur_c, tgt_c, vel_c;
  wide_t       a3_c, fm_c;
  logic [23:0] x_new;
  logic        clamp_w, overshoot;
  logic signed [34:0] g_c;
  logic signed [33:0] d_c;
  logic signed [48:0] e_c;

  sdf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  sdf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .rem0_i    (div_rem0),
    .stream_i  (div_stream),
    .divisor_i (div_divisor),
    .done_o    (div_done_w),
    .quo_o     (div_quo),
    .exact_o   (div_exact)
  );

  // Values of the axis in work.
  assign chv_c = chv_q[ax_q];
  assign cur_c = cur_q[ax_q];
  assign tgt_c = tgt_q[ax_q];
  assign vel_c = vel_q[ax_q];
  assign a3_c  = wadd(49'(chv_c), 49'(tm_q[ax_q]));
  assign fm_c  = fmul_res(mul_prod, 1'b0);
  assign g_c   = 35'(cur_c) - 35'(chv_c);
  assign d_c   = 34'(tgt_c) - 34'(cur_c);
  assign e_c   = 49'(o_q[ax_q]) - 49'(tgt_c);
  assign dec_num = 40'h1_0000_0000 + (den_q >> 1);

  assign is_div = (step_q == ST_OMEGA) || (step_q == ST_DECAY) ||
                  (step_q == ST_ROOT) || (step_q == ST_RATIO);
  assign unit_done = is_div ? div_done_w : mul_done;
  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign wb_en     = (state_q == S_WAIT) && unit_done;
  assign last      = (step_q == ST_DOT) && ax_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign overshoot = (dot_q > 86'sd0);

  // Capped x from the omega times time step product.
  assign x_new = ((|mul_prod[95:40]) || (mul_prod[39:16] > X_CAP)) ? X_CAP
                                                                     : mul_prod[39:16];

  // Clamp test from the square root result.
  assign clamp_w = (46'(div_quo[32:0]) > lim_q) ||
                   ((46'(div_quo[32:0]) == lim_q) && !div_exact);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ISSUE;
      S_ISSUE: state_d = S_WAIT;
      S_WAIT:  if (unit_done) state_d = last ? S_DONE : S_ISSUE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Unit requests for the step being issued.
  always_comb begin
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    div_rem0    = '0;
    div_stream  = '0;
    div_divisor = '0;
    if (state_q == S_ISSUE) begin
      mul_start = !is_div;
      unique case (step_q)
        ST_OMEGA: begin
          div_req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: 6'd34};
          div_stream  = {1'b1, 77'b0};
          div_divisor = 40'(st_q);
        end
        ST_X: begin
          mul_a = 48'(omega_q);
          mul_b = 48'(dt_q);
        end
        ST_X2: begin
          mul_a = 48'(x_q);
          mul_b = 48'(x_q);
        end
        ST_X3: begin
          mul_a = 48'(x2_q);
          mul_b = 48'(x_q);
        end
        ST_K1: begin
          mul_a = K048;
          mul_b = 48'(x2_q);
        end
        ST_K2: begin
          mul_a = K0235;
          mul_b = 48'(x3_q);
        end
        ST_DECAY: begin
          div_req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: 6'd18};
          div_rem0    = 40'(dec_num[39:18]);
          div_stream  = {dec_num[17:0], 60'b0};
          div_divisor = den_q;
        end
        ST_LIM: begin
          mul_a = 48'(st_q);
          mul_b = 48'(max_speed_q);
        end
        ST_SQ: begin
          mul_a = magw(49'(chv_c));
          mul_b = magw(49'(chv_c));
        end
        ST_ROOT: begin
          div_req    = '{start: 1'b1, sqrt_mode: 1'b1, steps: 6'd33};
          div_stream = {sq_q, 12'b0};
        end
        ST_RATIO: begin
          div_req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: 6'd32};
          div_rem0    = 40'(lim_q[45:1]);
          div_stream  = {lim_q[0], 77'b0};
          div_divisor = 40'(root_q);
        end
        ST_SC: begin
          mul_a = magw(49'(chv_c));
          mul_b = 48'(ratio_q);
        end
        ST_P1: begin
          mul_a = 48'(omega_q);
          mul_b = magw(49'(chv_c));
        end
        ST_TM: begin
          mul_a = magw(49'(wa_q[ax_q]));
          mul_b = 48'(dt_q);
        end
        ST_P2: begin
          mul_a = 48'(omega_q);
          mul_b = magw(49'(tm_q[ax_q]));
        end
        ST_NV: begin
          mul_a = magw(49'(wa_q[ax_q]));
          mul_b = 48'(decay_q);
        end
        ST_Q: begin
          mul_a = magw(49'(a3_c));
          mul_b = 48'(decay_q);
        end
        ST_DOT: begin
          mul_a = magw(e_c);
          mul_b = magw(49'(d_c));
        end
        default: mul_start = 1'b0;
      endcase
    end
  end

  // Step order; the per-axis steps run x first, then y.
  always_comb begin
    step_nx = step_q;
    ax_nx   = ax_q;
    unique case (step_q)
      ST_OMEGA: step_nx = ST_X;
      ST_X:     step_nx = ST_X2;
      ST_X2:    step_nx = ST_X3;
      ST_X3:    step_nx = ST_K1;
      ST_K1:    step_nx = ST_K2;
      ST_K2:    step_nx = ST_DECAY;
      ST_DECAY: step_nx = ST_LIM;
      ST_LIM:   step_nx = ST_SQ;
      ST_SQ: begin
        ax_nx = !ax_q;
        if (ax_q) step_nx = ST_ROOT;
      end
      ST_ROOT:  step_nx = clamp_w ? ST_RATIO : ST_P1;
      ST_RATIO: step_nx = ST_SC;
      ST_SC: begin
        ax_nx = !ax_q;
        if (ax_q) step_nx = ST_P1;
      end
      ST_P1:    step_nx = ST_TM;
      ST_TM:    step_nx = ST_P2;
      ST_P2:    step_nx = ST_NV;
      ST_NV:    step_nx = ST_Q;
      ST_Q:     step_nx = ST_DOT;
      ST_DOT: begin
        if (!ax_q) begin
          ax_nx   = 1'b1;
          step_nx = ST_P1;
        end
      end
      default:  step_nx = ST_OMEGA;
    endcase
  end

  // Control state, configuration and the kept velocity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= ST_OMEGA;
      ax_q          <= 1'b0;
      smooth_time_q <= ST_RESET;
      max_speed_q   <= MS_RESET;
      vel_q[0]      <= '0;
      vel_q[1]      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= ST_OMEGA;
        ax_q   <= 1'b0;
      end else if (wb_en) begin
        step_q <= step_nx;
        ax_q   <= ax_nx;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SMOOTH_TIME: smooth_time_q <= cfg_data_i;
          CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i;
          default:         smooth_time_q <= smooth_time_q;
        endcase
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        vel_q[0]    <= overshoot ? 32'sd0 : sat32(49'(nv_q[0]));
        vel_q[1]    <= overshoot ? 32'sd0 : sat32(49'(nv_q[1]));
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath write-back of each step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q[0] <= in_word_i.current_x;
      cur_q[1] <= in_word_i.current_y;
      tgt_q[0] <= in_word_i.target_x;
      tgt_q[1] <= in_word_i.target_y;
      chv_q[0] <= 34'(in_word_i.current_x) - 34'(in_word_i.target_x);
      chv_q[1] <= 34'(in_word_i.current_y) - 34'(in_word_i.target_y);
      dt_q     <= in_word_i.delta_time;
      st_q     <= (smooth_time_q < ST_MIN) ? ST_MIN : smooth_time_q;
      sq_q     <= '0;
      dot_q    <= '0;
    end else if (wb_en) begin
      unique case (step_q)
        ST_OMEGA: omega_q <= div_quo[30:0];
        ST_X: begin
          x_q   <= x_new;
          den_q <= 40'h1_0000 + 40'(x_new);
        end
        ST_X2:    x2_q <= mul_prod[46:16];
        ST_X3:    x3_q <= mul_prod[53:16];
        ST_K1:    den_q <= den_q + mul_prod[55:16];
        ST_K2:    den_q <= den_q + mul_prod[55:16];
        ST_DECAY: decay_q <= div_quo[16:0];
        ST_LIM:   lim_q <= mul_prod[61:16];
        ST_SQ:    sq_q <= sq_q + mul_prod[65:0];
        ST_ROOT:  root_q <= div_quo[32:0];
        ST_RATIO: ratio_q <= div_quo[31:0];
        ST_SC: begin
          chv_q[ax_q] <= chv_c[33] ? -$signed({1'b0, mul_prod[63:31]})
                                   : $signed({1'b0, mul_prod[63:31]});
        end
        ST_P1:    wa_q[ax_q] <= wadd(49'(vel_c), chv_c[33] ? 49'(-fm_c) : 49'(fm_c));
        ST_TM:    tm_q[ax_q] <= wa_q[ax_q][47] ? -fm_c : fm_c;
        ST_P2:    wa_q[ax_q] <= wadd(49'(vel_c), tm_q[ax_q][47] ? 49'(fm_c) : 49'(-fm_c));
        ST_NV:    nv_q[ax_q] <= wa_q[ax_q][47] ? -fm_c : fm_c;
        ST_Q:     o_q[ax_q] <= wadd(49'(g_c), a3_c[47] ? 49'(-fm_c) : 49'(fm_c));
        ST_DOT: begin
          if (d_c[33] != e_c[48]) dot_q <= dot_q - 86'(mul_prod);
          else                    dot_q <= dot_q + 86'(mul_prod);
        end
        default:  dot_q <= dot_q;
      endcase
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_q.position_x <= overshoot ? tgt_q[0] : sat32(49'(o_q[0]));
      out_q.position_y <= overshoot ? tgt_q[1] : sat32(49'(o_q[1]));
      out_q.speed_x    <= overshoot ? 32'sd0 : sat32(49'(nv_q[0]));
      out_q.speed_y    <= overshoot ? 32'sd0 : sat32(49'(nv_q[1]));
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== tb/sv/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// sdf_checker: prediction and comparison for the smooth damp follower
// Watches the config, input and output channels, computes the expected output
// word of every accepted input word and compares each output word with the
// oldest expectation.
// ----------------------------------------------------------------------------
module sdf_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  sdf_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  sdf_pkg::out_word_t out_word_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdf_pkg::*;

  localparam longint WMAX = 64'sh7FFF_FFFF_FFFF;

  logic [30:0]       smooth_time_q;
  logic [30:0]       max_speed_q;
  longint            vel_x_q;
  longint            vel_y_q;
  out_word_t         expected_words[$];
  int                errors;

  assign errors_o  = errors;
  assign pending_o = expected_words.size();

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint sat_wide(longint v);
    if (v > WMAX) return WMAX;
    if (v < -WMAX) return -WMAX;
    return v;
  endfunction

  // Q16.16 product with the magnitude truncated and saturated.
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    p = 128'(mag64(a)) * 128'(mag64(b));
    p = p >> 16;
    if (p > 128'(WMAX)) p = 128'(WMAX);
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint scale_down(longint c, logic [63:0] ratio);
    logic [63:0] m;
    m = (mag64(c) * ratio) >> 31;
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  // One follower update; advances the kept velocity.
  function automatic out_word_t follow_step(in_word_t w);
    logic [63:0] st, omega, x, x2, x3, den, lim, root, ratio;
    logic [127:0] sq, trial;
    logic signed [127:0] d1a, d1b, d2a, d2b, dot;
    longint cx, cy, tx, ty, decay, chx, chy, gx, gy, tmx, tmy, nvx, nvy, ox, oy;
    logic exact;
    out_word_t r;
    cx = w.current_x;
    cy = w.current_y;
    tx = w.target_x;
    ty = w.target_y;
    st = (smooth_time_q < ST_MIN) ? 64'(ST_MIN) : 64'(smooth_time_q);
    omega = (64'd1 << 33) / st;
    x = (omega * 64'(w.delta_time)) >> 16;
    if (x > 64'(X_CAP)) x = 64'(X_CAP);
    x2 = (x * x) >> 16;
    x3 = (x2 * x) >> 16;
    den = 64'd65536 + x + ((64'(K048) * x2) >> 16) + ((64'(K0235) * x3) >> 16);
    decay = longint'(((64'd1 << 32) + den / 2) / den);

    // Limit the offset to the target by its exact length.
    chx = cx - tx;
    chy = cy - ty;
    lim = (64'(max_speed_q) * st) >> 16;
    sq = 128'(mag64(chx)) * 128'(mag64(chx)) + 128'(mag64(chy)) * 128'(mag64(chy));
    root = 0;
    for (int b = 34; b >= 0; b--) begin
      trial = 128'(root | (64'd1 << b));
      if (trial * trial <= sq) root = root | (64'd1 << b);
    end
    exact = (128'(root) * 128'(root) == sq);
    if (root > lim || (root == lim && !exact)) begin
      ratio = (lim << 31) / root;
      chx = scale_down(chx, ratio);
      chy = scale_down(chy, ratio);
    end
    gx = cx - chx;
    gy = cy - chy;

    tmx = qmul(sat_wide(vel_x_q + qmul(longint'(omega), chx)), longint'(w.delta_time));
    tmy = qmul(sat_wide(vel_y_q + qmul(longint'(omega), chy)), longint'(w.delta_time));
    nvx = qmul(sat_wide(vel_x_q - qmul(longint'(omega), tmx)), decay);
    nvy = qmul(sat_wide(vel_y_q - qmul(longint'(omega), tmy)), decay);
    ox = sat_wide(gx + qmul(sat_wide(chx + tmx), decay));
    oy = sat_wide(gy + qmul(sat_wide(chy + tmy), decay));

    // Overshoot: snap to the target and stop.
    d1a = tx - cx;
    d1b = ox - tx;
    d2a = ty - cy;
    d2b = oy - ty;
    dot = d1a * d1b + d2a * d2b;
    if (dot > 0) begin
      ox = tx;
      oy = ty;
      nvx = 0;
      nvy = 0;
    end
    vel_x_q = longint'(clip32(nvx));
    vel_y_q = longint'(clip32(nvy));
    r.position_x = clip32(ox);
    r.position_y = clip32(oy);
    r.speed_x = vel_x_q[31:0];
    r.speed_y = vel_y_q[31:0];
    return r;
  endfunction

  // Track config writes, predict on input words, compare output words.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      smooth_time_q = ST_RESET;
      max_speed_q = MS_RESET;
      vel_x_q = 0;
      vel_y_q = 0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SMOOTH_TIME) smooth_time_q = cfg_data_i;
        else max_speed_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(follow_step(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word %h", out_word_i);
        end else begin
          e = expected_words.pop_front();
          if (e !== out_word_i) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: pos %h %h spd %h %h, expected pos %h %h spd %h %h",
                       out_word_i.position_x, out_word_i.position_y,
                       out_word_i.speed_x, out_word_i.speed_y,
                       e.position_x, e.position_y, e.speed_x, e.speed_y);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_smooth_damp_follower_2d.sv =====
// ----------------------------------------------------------------------------
// tb_smooth_damp_follower_2d: stimulus for the smooth damp follower
// Drives directed and random input words through several register settings
// and idle patterns, holds off the output for a long stretch once, and gives
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_smooth_damp_follower_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import sdf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SMOOTH_TIME;
  logic [30:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_out = 1'b0;

  smooth_damp_follower_2d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  sdf_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit far above the slowest correct run.
  initial begin
    #50ms;
    $display("smooth_damp_follower_2d test failed");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one word, idling at random first; returns just after acceptance.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // One register write; the valid drops for a cycle before the next write.
  task automatic write_reg(logic idx, logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected word, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(99) < 30) return $urandom;
    return $signed($urandom) >>> $urandom_range(8, 24);
  endfunction

  function automatic logic [16:0] rand_dt();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 17'd0;
    if (r < 14) return 17'd65536;
    if (r < 50) return 17'($urandom_range(0, 4000));
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic in_word_t mk(logic signed [31:0] cx, logic signed [31:0] cy,
                                  logic signed [31:0] tx, logic signed [31:0] ty,
                                  logic [16:0] dt);
    in_word_t w;
    w.current_x = cx;
    w.current_y = cy;
    w.target_x = tx;
    w.target_y = ty;
    w.delta_time = dt;
    return w;
  endfunction

  // Random phase: mostly short follow runs stepping toward a fixed target.
  task automatic random_words(int n);
    in_word_t w;
    w = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_dt());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) begin
        w = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_dt());
      end else begin
        w.current_x = w.current_x + ((w.target_x - w.current_x) >>> $urandom_range(1, 4));
        w.current_y = w.current_y + ((w.target_y - w.current_y) >>> $urandom_range(1, 4));
        w.delta_time = rand_dt();
      end
      send_word(w);
    end
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: extremes, zero step, snap, overshoot.
    send_word(mk(0, 0, 0, 0, 17'd0));
    send_word(mk(0, 0, 32'sh10000, 32'sh20000, 17'd1092));
    send_word(mk(0, 0, 32'sh10000, 32'sh20000, 17'd0));
    send_word(mk(PMAX, PMAX, PMIN, PMIN, 17'd65536));
    send_word(mk(PMIN, PMIN, PMAX, PMAX, 17'd65536));
    send_word(mk(PMIN, PMAX, PMAX, PMIN, 17'd1));
    send_word(mk(32'sh1000, 0, 0, 0, 17'd65536));
    send_word(mk(-32'sh1000, 32'sh5, 0, 0, 17'd30000));
    send_word(mk(32'sh50000, 32'sh50000, 32'sh50000, 32'sh50000, 17'd65536));
    send_word(mk(-1, -1, 0, 0, 17'h1FFFF & 17'd65535));
    send_word(mk(32'sh10000, 32'sh0, 32'sh10001, 32'sh0, 17'd40000));
    drain();

    // Offset clamp and the smallest smooth time.
    write_reg(CFG_SMOOTH_TIME, 31'd0);
    write_reg(CFG_MAX_SPEED, 31'd65536);
    send_word(mk(0, 0, 32'sh7FFF0000, 32'sh100, 17'd65536));
    send_word(mk(0, 0, 32'sh30000, 32'sh40000, 17'd1));
    send_word(mk(PMAX, PMIN, PMIN, PMAX, 17'd655));
    drain();
    write_reg(CFG_SMOOTH_TIME, 31'h7FFF_FFFF);
    write_reg(CFG_MAX_SPEED, 31'd0);
    send_word(mk(32'sh10000, 32'sh10000, 0, 0, 17'd65536));
    send_word(mk(PMAX, 0, 0, PMIN, 17'd65536));
    drain();
    write_reg(CFG_SMOOTH_TIME, ST_RESET);
    write_reg(CFG_MAX_SPEED, MS_RESET);

    // Long output hold-off while words keep coming.
    hold_out = 1'b1;
    random_words(40);
    drain();

    // Random phases over settings and idle patterns.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 60; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 60; end
        3: begin send_idle = 28; recv_stall = 28; end
        4: begin send_idle = 0;  recv_stall = 0;  end
        default: begin send_idle = 28; recv_stall = 60; end
      endcase
      case (p)
        0: begin write_reg(CFG_SMOOTH_TIME, ST_RESET); write_reg(CFG_MAX_SPEED, MS_RESET); end
        1: begin write_reg(CFG_SMOOTH_TIME, 31'd7); write_reg(CFG_MAX_SPEED, 31'd1000); end
        2: begin
          write_reg(CFG_SMOOTH_TIME, 31'h7FFF_FFFF);
          write_reg(CFG_MAX_SPEED, 31'h7FFF_FFFF);
        end
        3: begin write_reg(CFG_SMOOTH_TIME, 31'd65536); write_reg(CFG_MAX_SPEED, 31'd0); end
        4: begin
          write_reg(CFG_SMOOTH_TIME, 31'($urandom_range(3, 200000)));
          write_reg(CFG_MAX_SPEED, 31'($urandom));
        end
        default: begin
          write_reg(CFG_SMOOTH_TIME, 31'd3);
          write_reg(CFG_MAX_SPEED, 31'($urandom_range(1, 1 << 22)));
        end
      endcase
      random_words(240);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("smooth_damp_follower_2d test passed");
    end else begin
      $display("smooth_damp_follower_2d test failed");
    end
    $finish;
  end
endmodule
